>>> design/sbt_pkg.sv
// Shared types and constants of the software breakpoint table.
// Used by sbt_ctrl, sbt_datapath and software_breakpoint_table; depends on nothing.
`timescale 1ns / 1ps

package sbt_pkg;

  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
  localparam int          MAX_PATCH   = 16;
  localparam int          PATCH_CNT_W = 5;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_UPDATE = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ACT_ADDED     = 3'd0,
    ACT_REMOVED   = 3'd1,
    ACT_FULL      = 3'd2,
    ACT_NOT_FOUND = 3'd3,
    ACT_EBREAK    = 3'd4,
    ACT_RESTORE   = 3'd5
  } action_e;

  typedef struct packed {
    logic    clr_wr;
    logic    load;
    logic    rd_en;
    logic    adv;
    logic    ent_wr;
    logic    sav_wr;
    logic    pend_ld;
    action_e pend_act;
    logic    push_pend;
    logic    cnt_inc;
    logic    flush_out;
  } sbt_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       in_ignore;
    logic [1:0] req;
    logic       slot_empty;
    logic       addr_match;
    logic       wanted;
    logic       applied;
    logic       last_slot;
    logic       patch_last;
    logic       pend_valid;
    logic       out_free;
  } sbt_status_t;

endpackage

>>> design/sbt_ctrl.sv
// Sequencer of the breakpoint table: clearing pass, slot scan and result flush.
// Depends on sbt_pkg for the command and status structs.
`timescale 1ns / 1ps

module sbt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sbt_pkg::sbt_status_t status_i,
  output sbt_pkg::sbt_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;
  logic   patch;

  assign patch = !status_i.slot_empty && (status_i.wanted != status_i.applied);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && !status_i.in_ignore) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        case (status_i.req)
          sbt_pkg::REQ_ADD: begin
            if (status_i.slot_empty) begin
              cmd_o.ent_wr   = 1'b1;
              cmd_o.sav_wr   = 1'b1;
              cmd_o.pend_ld  = 1'b1;
              cmd_o.pend_act = sbt_pkg::ACT_ADDED;
              state_d        = ST_FLUSH;
            end else if (status_i.last_slot) begin
              cmd_o.pend_ld  = 1'b1;
              cmd_o.pend_act = sbt_pkg::ACT_FULL;
              state_d        = ST_FLUSH;
            end else begin
              cmd_o.adv   = 1'b1;
              cmd_o.rd_en = 1'b1;
            end
          end
          sbt_pkg::REQ_REMOVE: begin
            if (status_i.addr_match && status_i.wanted) begin
              cmd_o.ent_wr   = 1'b1;
              cmd_o.pend_ld  = 1'b1;
              cmd_o.pend_act = sbt_pkg::ACT_REMOVED;
              state_d        = ST_FLUSH;
            end else if (status_i.last_slot) begin
              cmd_o.pend_ld  = 1'b1;
              cmd_o.pend_act = sbt_pkg::ACT_NOT_FOUND;
              state_d        = ST_FLUSH;
            end else begin
              cmd_o.adv   = 1'b1;
              cmd_o.rd_en = 1'b1;
            end
          end
          default: begin
            // hold while an earlier patch cannot leave yet
            if (!(patch && status_i.pend_valid && !status_i.out_free)) begin
              cmd_o.ent_wr = 1'b1;
              if (patch) begin
                cmd_o.pend_ld   = 1'b1;
                cmd_o.pend_act  = status_i.wanted ? sbt_pkg::ACT_EBREAK
                                                  : sbt_pkg::ACT_RESTORE;
                cmd_o.cnt_inc   = 1'b1;
                cmd_o.push_pend = status_i.pend_valid;
              end
              if (status_i.last_slot || (patch && status_i.patch_last)) begin
                state_d = ST_FLUSH;
              end else begin
                cmd_o.adv   = 1'b1;
                cmd_o.rd_en = 1'b1;
              end
            end
          end
        endcase
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.flush_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      stall_q <= 1'b1;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != ST_IDLE);
    end
  end

  assign in_stall_o = stall_q;

endmodule

>>> design/sbt_datapath.sv
// Datapath of the breakpoint table: slot and saved-word memories, item and
// scan registers, pending result and output register. Depends on sbt_pkg.
`timescale 1ns / 1ps

module sbt_datapath #(
  parameter int HARTS = 2,
  parameter int TASKS = 16,
  parameter int SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           req_type_i,
  input  logic                 hart_index_i,
  input  logic [3:0]           task_index_i,
  input  logic [31:0]          target_address_i,
  input  logic [31:0]          original_word_i,
  input  sbt_pkg::sbt_cmd_t    cmd_i,
  output sbt_pkg::sbt_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           action_o,
  output logic [3:0]           slot_index_o,
  output logic [31:0]          patch_address_o,
  output logic [31:0]          patch_word_o,
  output logic                 patch_valid_o,
  output logic                 last_o
);

  localparam int GROUPS  = HARTS * TASKS;
  localparam int ENTRIES = GROUPS * SLOTS;
  localparam int GW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW      = sbt_pkg::PATCH_CNT_W;

  typedef struct packed {
    logic [31:0] addr;
    logic        wanted;
    logic        applied;
  } entry_t;

  entry_t      ent_mem [ENTRIES];
  logic [31:0] sav_mem [ENTRIES];

  entry_t      ent_rd_q;
  logic [31:0] sav_rd_q;
  entry_t      ent_wdata;
  logic        ent_we;
  logic [EW-1:0] ent_waddr, cur_addr, rd_addr;
  logic [SW-1:0] rd_slot;

  logic [EW-1:0] clr_ptr_q;
  logic [1:0]    req_q;
  logic [GW-1:0] group_q;
  logic [31:0]   taddr_q, orig_q;
  logic [SW-1:0] slot_q;
  logic [CW-1:0] cnt_q;

  logic             pend_valid_q;
  sbt_pkg::action_e pend_act_q;
  logic [3:0]       pend_slot_q;
  logic [31:0]      pend_addr_q, pend_word_q;
  logic             pend_pv_q;

  logic [3:0]  new_slot;
  logic [31:0] new_addr, new_word;
  logic        new_pv;

  logic             out_valid_q, out_pv_q, out_last_q;
  sbt_pkg::action_e out_act_q;
  logic [3:0]       out_slot_q;
  logic [31:0]      out_addr_q, out_word_q;
  logic             out_free;
  logic             addr_req;

  // Entry address of a slot within the current group
  assign rd_slot  = cmd_i.adv ? slot_q + SW'(1) : slot_q;
  assign cur_addr = EW'(32'(group_q) * SLOTS + 32'(slot_q));
  assign rd_addr  = EW'(32'(group_q) * SLOTS + 32'(rd_slot));

  assign ent_we    = cmd_i.clr_wr || cmd_i.ent_wr;
  assign ent_waddr = cmd_i.clr_wr ? clr_ptr_q : cur_addr;

  always_comb begin
    ent_wdata = '0;
    if (!cmd_i.clr_wr) begin
      case (req_q)
        sbt_pkg::REQ_ADD: begin
          ent_wdata = '{addr: taddr_q, wanted: 1'b1, applied: ent_rd_q.applied};
        end
        sbt_pkg::REQ_REMOVE: begin
          ent_wdata = '{addr: ent_rd_q.addr, wanted: 1'b0, applied: ent_rd_q.applied};
        end
        default: begin
          // applied follows wanted; a slot left disabled is freed
          ent_wdata = '{addr:    ent_rd_q.wanted ? ent_rd_q.addr : 32'd0,
                        wanted:  ent_rd_q.wanted,
                        applied: ent_rd_q.wanted};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (cmd_i.rd_en) ent_rd_q <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sav_wr) sav_mem[cur_addr] <= orig_q;
    if (cmd_i.rd_en) sav_rd_q <= sav_mem[rd_addr];
  end

  // Item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      group_q <= GW'(32'(hart_index_i) * TASKS + 32'(task_index_i));
      taddr_q <= target_address_i;
      orig_q  <= original_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
      slot_q    <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_ptr_q <= clr_ptr_q + EW'(1);
      if (cmd_i.load) begin
        slot_q <= '0;
        cnt_q  <= '0;
      end else begin
        if (cmd_i.adv) slot_q <= slot_q + SW'(1);
        if (cmd_i.cnt_inc) cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Build the pending result from the slot under evaluation
  always_comb begin
    new_slot = 4'(slot_q);
    new_addr = 32'd0;
    new_word = 32'd0;
    new_pv   = 1'b0;
    case (cmd_i.pend_act)
      sbt_pkg::ACT_ADDED, sbt_pkg::ACT_REMOVED: ;
      sbt_pkg::ACT_EBREAK: begin
        new_addr = ent_rd_q.addr;
        new_word = sbt_pkg::EBREAK_WORD;
        new_pv   = 1'b1;
      end
      sbt_pkg::ACT_RESTORE: begin
        new_addr = ent_rd_q.addr;
        new_word = sav_rd_q;
        new_pv   = 1'b1;
      end
      default: new_slot = 4'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.pend_ld) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_ld) begin
      pend_act_q  <= cmd_i.pend_act;
      pend_slot_q <= new_slot;
      pend_addr_q <= new_addr;
      pend_word_q <= new_word;
      pend_pv_q   <= new_pv;
    end
  end

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_pend || cmd_i.flush_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_pend || (cmd_i.flush_out && pend_valid_q)) begin
      out_act_q  <= pend_act_q;
      out_slot_q <= pend_slot_q;
      out_addr_q <= pend_addr_q;
      out_word_q <= pend_word_q;
      out_pv_q   <= pend_pv_q;
      out_last_q <= cmd_i.flush_out;
    end else if (cmd_i.flush_out) begin
      out_act_q  <= sbt_pkg::ACT_RESTORE;
      out_slot_q <= 4'd0;
      out_addr_q <= 32'd0;
      out_word_q <= 32'd0;
      out_pv_q   <= 1'b0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_act_q;
  assign slot_index_o    = out_slot_q;
  assign patch_address_o = out_addr_q;
  assign patch_word_o    = out_word_q;
  assign patch_valid_o   = out_pv_q;
  assign last_o          = out_last_q;

  // Status back to the sequencer
  assign addr_req = (req_type_i == sbt_pkg::REQ_ADD) || (req_type_i == sbt_pkg::REQ_REMOVE);

  assign status_o.clr_done   = (32'(clr_ptr_q) == ENTRIES - 1);
  assign status_o.in_ignore  = ((req_type_i != sbt_pkg::REQ_ADD) &&
                                (req_type_i != sbt_pkg::REQ_REMOVE) &&
                                (req_type_i != sbt_pkg::REQ_UPDATE)) ||
                               (addr_req && (target_address_i == 32'd0)) ||
                               (32'(hart_index_i) >= HARTS) ||
                               (32'(task_index_i) >= TASKS);
  assign status_o.req        = req_q;
  assign status_o.slot_empty = (ent_rd_q.addr == 32'd0);
  assign status_o.addr_match = (ent_rd_q.addr == taddr_q);
  assign status_o.wanted     = ent_rd_q.wanted;
  assign status_o.applied    = ent_rd_q.applied;
  assign status_o.last_slot  = (32'(slot_q) == SLOTS - 1);
  assign status_o.patch_last = (cnt_q == CW'(sbt_pkg::MAX_PATCH - 1));
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

endmodule

>>> design/software_breakpoint_table.sv
// Software breakpoint table, top level: sequencer plus datapath.
// An add or remove scans its group from slot 0 until it is settled; one item is taken at
// a time. An update scans one slot a cycle while no patch waits on a held output, and
// ends at the last slot or at its MAX_PATCH-th patch; the flush waits while the output stalls.
// Reset: a pass over all HARTS*TASKS*SLOTS entries (512 by default) empties the slot
// memory, with in_stall_o high throughout. Depends on sbt_pkg, sbt_ctrl, sbt_datapath.
`timescale 1ns / 1ps

module software_breakpoint_table #(
  parameter int HARTS = 2,
  parameter int TASKS = 16,
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic        hart_index_i,
  input  logic [3:0]  task_index_i,
  input  logic [31:0] target_address_i,
  input  logic [31:0] original_word_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [3:0]  slot_index_o,
  output logic [31:0] patch_address_o,
  output logic [31:0] patch_word_o,
  output logic        patch_valid_o,
  output logic        last_o
);

  // Commands flow from the sequencer to the datapath, flags flow back.
  sbt_pkg::sbt_cmd_t    cmd;
  sbt_pkg::sbt_status_t status;

  // The sequencer clears the memory, accepts a request word, then walks the addressed
  // group one slot per cycle, unless a patch waits on the output, until the request is settled.
  sbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the slot memories and keeps one result in hand, so the
  // final patch of an update can be flagged last once the scan has ended.
  sbt_datapath #(
    .HARTS (HARTS),
    .TASKS (TASKS),
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (req_type_i),
    .hart_index_i     (hart_index_i),
    .task_index_i     (task_index_i),
    .target_address_i (target_address_i),
    .original_word_i  (original_word_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .slot_index_o     (slot_index_o),
    .patch_address_o  (patch_address_o),
    .patch_word_o     (patch_word_o),
    .patch_valid_o    (patch_valid_o),
    .last_o           (last_o)
  );

  // Never push a held result over one still waiting at the output.
  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push_pend || cmd.flush_out) |-> status.out_free)
    else $error("result pushed while output word was held");

  // A flush always closes the item with a last word.
  a_flush_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush_out |=> (out_valid_o && last_o))
    else $error("flush did not present a last word");

  // An enabling patch always carries the ebreak word.
  a_ebreak_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == sbt_pkg::ACT_EBREAK)) |->
      (patch_valid_o && (patch_word_o == sbt_pkg::EBREAK_WORD)))
    else $error("ebreak patch with wrong word");

  // Add and remove replies are single words.
  a_reply_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o != sbt_pkg::ACT_EBREAK) &&
     (action_o != sbt_pkg::ACT_RESTORE)) |-> (last_o && !patch_valid_o))
    else $error("add or remove reply not a single word");

endmodule

>>> dv/sbt_tb_pkg.sv
// Scoreboard for the software breakpoint table testbench: slot-table predictor and
// result checker. Depends on sbt_pkg for request and action codes.
`timescale 1ns / 1ps

package sbt_tb_pkg;
  import sbt_pkg::*;

  localparam int          HARTS       = 2;
  localparam int          TASKS       = 16;
  localparam int          SLOTS       = 16;
  localparam int          ENTRIES     = HARTS * TASKS * SLOTS;
  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    action_e     action;
    logic [3:0]  slot;
    logic [31:0] patch_address;
    logic [31:0] patch_word;
    logic        patch_valid;
    logic        last;
  } breakpoint_result_t;

  class breakpoint_scoreboard;
    logic [31:0]        slot_addr [ENTRIES];
    bit                 wanted    [ENTRIES];
    bit                 applied   [ENTRIES];
    logic [31:0]        saved     [ENTRIES];
    breakpoint_result_t expected_q[$];
    int                 mismatches;

    function new();
      foreach (slot_addr[i]) begin
        slot_addr[i] = '0;
        saved[i]     = '0;
      end
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Random address held in a group, or zero when the group is empty.
    function logic [31:0] held_address(logic hart, logic [3:0] tsk);
      int          base;
      logic [31:0] pool[$];
      base = (hart * TASKS + tsk) * SLOTS;
      for (int s = 0; s < SLOTS; s++)
        if (slot_addr[base + s] != 0) pool.push_back(slot_addr[base + s]);
      if (pool.size() == 0) return '0;
      return pool[$urandom_range(pool.size() - 1)];
    endfunction

    // Apply one accepted request to the table and queue the words it should cause.
    function void note_request(logic [1:0] req, logic hart, logic [3:0] tsk,
                               logic [31:0] addr, logic [31:0] orig);
      int                 base;
      int                 e;
      int                 n;
      bit                 found;
      breakpoint_result_t r;
      if (req == REQ_UNKNOWN) return;
      base  = (hart * TASKS + tsk) * SLOTS;
      found = 1'b0;
      r     = '0;
      r.last = 1'b1;
      case (req)
        REQ_ADD: begin
          if (addr == 0) return;
          r.action = ACT_FULL;
          for (int s = 0; s < SLOTS && !found; s++) begin
            e = base + s;
            if (slot_addr[e] == 0) begin
              slot_addr[e] = addr;
              saved[e]     = orig;
              wanted[e]    = 1'b1;
              r.action     = ACT_ADDED;
              r.slot       = s[3:0];
              found        = 1'b1;
            end
          end
          expected_q.push_back(r);
        end
        REQ_REMOVE: begin
          if (addr == 0) return;
          r.action = ACT_NOT_FOUND;
          for (int s = 0; s < SLOTS && !found; s++) begin
            e = base + s;
            if (slot_addr[e] == addr && wanted[e]) begin
              wanted[e] = 1'b0;
              r.action  = ACT_REMOVED;
              r.slot    = s[3:0];
              found     = 1'b1;
            end
          end
          expected_q.push_back(r);
        end
        default: begin
          n = 0;
          for (int s = 0; s < SLOTS && n < MAX_PATCH; s++) begin
            e = base + s;
            if (slot_addr[e] != 0) begin
              if (wanted[e] != applied[e]) begin
                r               = '0;
                r.slot          = s[3:0];
                r.patch_address = slot_addr[e];
                r.patch_valid   = 1'b1;
                if (wanted[e]) begin
                  r.action     = ACT_EBREAK;
                  r.patch_word = EBREAK_WORD;
                  applied[e]   = 1'b1;
                end else begin
                  r.action     = ACT_RESTORE;
                  r.patch_word = saved[e];
                  applied[e]   = 1'b0;
                  slot_addr[e] = '0;
                end
                expected_q.push_back(r);
                n++;
              end else if (!wanted[e]) begin
                slot_addr[e] = '0;
              end
            end
          end
          if (n == 0) begin
            r        = '0;
            r.action = ACT_RESTORE;
            r.last   = 1'b1;
            expected_q.push_back(r);
          end else begin
            r      = expected_q.pop_back();
            r.last = 1'b1;
            expected_q.push_back(r);
          end
        end
      endcase
    endfunction

    function string show(breakpoint_result_t r);
      return $sformatf("action %0d slot %0d address %h word %h patch %b last %b",
                       r.action, r.slot, r.patch_address, r.patch_word,
                       r.patch_valid, r.last);
    endfunction

    function void check_result(breakpoint_result_t got);
      breakpoint_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.action !== want.action || got.slot !== want.slot ||
          got.patch_address !== want.patch_address || got.patch_word !== want.patch_word ||
          got.patch_valid !== want.patch_valid || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected %s", show(want));
          $display("                 actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
// Testbench top for software_breakpoint_table: directed and random request words,
// random idling on both sides, one long output hold-off. Depends on sbt_pkg, sbt_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
  import sbt_pkg::*;
  import sbt_tb_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_WORDS = 82;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4 * (SLOTS + 3);

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i       = REQ_UPDATE;
  logic        hart_index_i     = 1'b0;
  logic [3:0]  task_index_i     = '0;
  logic [31:0] target_address_i = '0;
  logic [31:0] original_word_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [2:0]  action_o;
  logic [3:0]  slot_index_o;
  logic [31:0] patch_address_o;
  logic [31:0] patch_word_o;
  logic        patch_valid_o;
  logic        last_o;

  breakpoint_scoreboard sb;
  breakpoint_result_t   got;
  int                   words_sent  = 0;
  int                   cycle_count = 0;
  logic                 calm        = 1'b0;   // no idling on either side while set
  logic                 hold_off    = 1'b0;   // long output stall while set

  software_breakpoint_table uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .hart_index_i    (hart_index_i),
    .task_index_i    (task_index_i),
    .target_address_i(target_address_i),
    .original_word_i (original_word_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .slot_index_o    (slot_index_o),
    .patch_address_o (patch_address_o),
    .patch_word_o    (patch_word_o),
    .patch_valid_o   (patch_valid_o),
    .last_o          (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Random nonzero breakpoint address.
  function automatic logic [31:0] any_address();
    logic [31:0] a;
    a = $urandom();
    if (a == 0) a = 32'h0000_0004;
    return a;
  endfunction

  // Offer one request word, idling first at random; hold it until accepted, then
  // hand it to the predictor. Valid stays high into the next word when no idle follows.
  task automatic send_word(input logic [1:0] req, input logic hart, input logic [3:0] tsk,
                           input logic [31:0] addr, input logic [31:0] orig);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= req;
    hart_index_i     <= hart;
    task_index_i     <= tsk;
    target_address_i <= addr;
    original_word_i  <= orig;
    @(posedge clk_i);
    // in_stall_o read here is the value the block saw at this edge
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req, hart, tsk, addr, orig);
    words_sent++;
  endtask

  // Result side: check every accepted word against the oldest prediction, then pick
  // the stall for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.action        = action_e'(action_o);
      got.slot          = slot_index_o;
      got.patch_address = patch_address_o;
      got.patch_word    = patch_word_o;
      got.patch_valid   = patch_valid_o;
      got.last          = last_o;
      sb.check_result(got);
    end
    out_stall_i <= hold_off || (!calm && $urandom_range(99) < 14);
  end

  // Hold the result side off for a long stretch mid-run so that the block backs up
  // and stalls its input while the sender keeps offering words.
  initial begin
    wait (words_sent >= 60);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    logic        hart;
    logic [3:0]  tsk;
    logic [31:0] addr;
    logic [31:0] held;
    logic        focus_hart[3];
    logic [3:0]  focus_task[3];
    int          work_words;
    int          pick;
    int          roll;

    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Empty group first: update with nothing to do.
    send_word(REQ_UPDATE, 1'b0, 4'd0, 32'h0, 32'h0);
    // Ignored words: add and remove of address zero, unknown request.
    send_word(REQ_ADD, 1'b0, 4'd0, 32'h0, 32'hFFFF_FFFF);
    send_word(REQ_REMOVE, 1'b0, 4'd0, 32'h0, 32'h0);
    send_word(REQ_UNKNOWN, 1'b1, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill the top group, extreme address and word in slot 0, then overflow it.
    send_word(REQ_ADD, 1'b1, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_ADD, 1'b1, 4'd15, 32'h0000_0001, 32'h0);
    for (int k = 2; k < SLOTS; k++)
      send_word(REQ_ADD, 1'b1, 4'd15, 32'h0000_1000 + 4 * k, $urandom());
    send_word(REQ_ADD, 1'b1, 4'd15, 32'h8000_0000, $urandom());
    // Sixteen patches in one update.
    send_word(REQ_UPDATE, 1'b1, 4'd15, 32'h0, 32'h0);
    // Remove, then remove again while the restore is still pending; restore it.
    send_word(REQ_REMOVE, 1'b1, 4'd15, 32'hFFFF_FFFF, 32'h0);
    send_word(REQ_REMOVE, 1'b1, 4'd15, 32'hFFFF_FFFF, 32'h0);
    send_word(REQ_UPDATE, 1'b1, 4'd15, 32'h0, 32'h0);
    // Removed before ever applied: freed silently on update.
    send_word(REQ_ADD, 1'b0, 4'd0, 32'h0000_0040, 32'h1234_5678);
    send_word(REQ_REMOVE, 1'b0, 4'd0, 32'h0000_0040, 32'h0);
    send_word(REQ_UPDATE, 1'b0, 4'd0, 32'h0, 32'h0);

    // Random part: most words go to a few busy groups so that slots fill, get
    // patched and get restored; the rest scatter over all groups.
    for (int k = 0; k < 3; k++) begin
      focus_hart[k] = 1'($urandom_range(1));
      focus_task[k] = 4'($urandom_range(15));
    end
    work_words = 0;
    while (work_words < RANDOM_WORDS) begin
      pick = $urandom_range(2);
      hart = focus_hart[pick];
      tsk  = focus_task[pick];
      if ($urandom_range(99) < 15) begin
        hart = 1'($urandom_range(1));
        tsk  = 4'($urandom_range(15));
      end
      calm <= (work_words >= 35 && work_words < 60);
      held = sb.held_address(hart, tsk);
      roll = $urandom_range(99);
      if (roll < 5) begin
        // fill burst: overflow the group, then patch it all
        repeat (SLOTS + 1) send_word(REQ_ADD, hart, tsk, any_address(), $urandom());
        send_word(REQ_UPDATE, hart, tsk, $urandom(), $urandom());
        work_words += SLOTS + 2;
      end else if (roll < 38) begin
        addr = (held != 0 && $urandom_range(99) < 20) ? held : any_address();
        send_word(REQ_ADD, hart, tsk, addr, $urandom());
        work_words++;
      end else if (roll < 65) begin
        addr = (held != 0 && $urandom_range(99) < 80) ? held : any_address();
        send_word(REQ_REMOVE, hart, tsk, addr, $urandom());
        work_words++;
      end else if (roll < 90) begin
        send_word(REQ_UPDATE, hart, tsk, $urandom(), $urandom());
        work_words++;
      end else begin
        // noise the block drops
        case ($urandom_range(2))
          0:       send_word(REQ_ADD, hart, tsk, 32'h0, $urandom());
          1:       send_word(REQ_REMOVE, hart, tsk, 32'h0, $urandom());
          default: send_word(REQ_UNKNOWN, hart, tsk, $urandom(), $urandom());
        endcase
        work_words++;
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then allow time for any stray word to show up.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
design/sbt_pkg.sv
design/sbt_ctrl.sv
design/sbt_datapath.sv
design/software_breakpoint_table.sv
dv/sbt_tb_pkg.sv
dv/tb_top.sv
